/* src/pbu_pkg.sv */
// Shared types and constants for the particle bounce update engine.
// Depends on nothing; every other file in src uses it by scoped names.
package pbu_pkg;

    // Table geometry and the fixed field widths.
    localparam int PARTICLE_COUNT = 1024;
    localparam int IDX_W          = 10;
    localparam int CFG_W          = 31;
    localparam int ITER_STEPS     = 32;

    // Request function codes.
    localparam logic FUNC_SPAWN = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SPEED_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_BOUNCE_SPEED = 2'd1;
    localparam logic [1:0] CFG_RADIUS       = 2'd2;
    localparam logic [1:0] CFG_LIFETIME     = 2'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0] SPEED_LIMIT_RST  = 31'd655360;
    localparam logic [CFG_W-1:0] BOUNCE_SPEED_RST = 31'd327680;
    localparam logic [CFG_W-1:0] RADIUS_RST       = 31'd19660800;
    localparam logic [15:0]      LIFETIME_RST     = 16'd1667;

    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   particle_index;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] start_vx;
        logic signed [31:0] start_vy;
        logic signed [31:0] start_vz;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               is_alive;
        logic [7:0]         hit_count;
        logic [8:0]         radius_size;
    } t_res;

    // Operation of the shared iterative unit.
    typedef enum logic {
        ITER_SQRT = 1'b0,
        ITER_DIV  = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_ctl;

endpackage

/* src/particle_bounce_update.sv */
// Top level of the particle bounce update engine: particle table, sequencer,
// shared multiplier and the iterative root/divide unit. Depends on pbu_pkg, pbu_iter.
//
// Requests are taken when i_start is high and o_busy is low. Each request gives one
// result on o_res, marked by o_done for exactly one cycle, and the receiver cannot
// stall it. A spawn request is answered in the next cycle and leaves the block
// ready. A step request on a dead particle is answered from ST_READ. A live particle
// may need a length normalization for the boundary bounce and one for the speed
// clamp. Each is done on the 32-step shared square-root/divide unit as one root and
// three divisions, so one step uses at most two roots and six divisions in turn. The
// block is ready again in the cycle in which the result strobe shows. After reset a
// clearing pass marks all 1024 table entries dead, one a cycle, and o_busy stays
// high until the pass ends.
module particle_bounce_update (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  pbu_pkg::t_req              i_req,
    output logic                       o_busy,
    output logic                       o_done,
    output pbu_pkg::t_res              o_res,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [pbu_pkg::CFG_W-1:0]  i_cfg_wdata
);

    typedef struct packed {
        logic               alive;
        logic [7:0]         hits;
        logic [15:0]        age;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_entry;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_SUMSQ = 9'b000001000,
        ST_SQRT  = 9'b000010000,
        ST_DMUL  = 9'b000100000,
        ST_DGO   = 9'b001000000,
        ST_DWAIT = 9'b010000000,
        ST_MOVE  = 9'b100000000
    } t_state;

    function automatic logic [31:0] mag32(input logic signed [31:0] c);
        mag32 = c[31] ? (32'd0 - c) : c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
        if (s[32] != s[31]) begin
            sat32 = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            sat32 = s[31:0];
        end
    endfunction

    // Control registers.
    t_state                    r_state, n_state;
    logic [2:0]                r_cnt, n_cnt;
    logic [1:0]                r_k, n_k;
    logic                      r_phase, n_phase;
    logic [pbu_pkg::IDX_W-1:0] r_clr, n_clr;
    logic                      r_done, n_done;
    logic [pbu_pkg::CFG_W-1:0] r_speed, r_bounce, r_radius;
    logic [15:0]               r_life;

    // Datapath registers.
    logic signed [31:0]        r_p [3];
    logic signed [31:0]        n_p [3];
    logic signed [31:0]        r_v [3];
    logic signed [31:0]        n_v [3];
    logic [15:0]               r_age, n_age;
    logic [7:0]                r_hits, n_hits;
    logic [pbu_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [63:0]               r_acc, n_acc;
    logic [63:0]               r_prod;
    logic [31:0]               r_len, n_len;
    pbu_pkg::t_res             r_out, n_out;

    // Particle table.
    t_entry                    r_mem [pbu_pkg::PARTICLE_COUNT];
    t_entry                    r_rd;
    logic                      mem_we;
    logic [pbu_pkg::IDX_W-1:0] mem_waddr;
    t_entry                    mem_wdata;

    // Shared unit and multiplier operands.
    pbu_pkg::t_iter_ctl        iter_ctl;
    logic [63:0]               iter_a;
    logic                      iter_done;
    logic [31:0]               iter_res;
    logic [31:0]               m_a, m_b;
    logic signed [31:0]        sel_c;
    logic [31:0]               limit, scale;

    logic                      accept;
    logic signed [31:0]        toward;
    logic signed [31:0]        mv_p [3];
    logic [15:0]               mv_age;
    logic                      mv_alive;

    assign accept = i_start && (r_state == ST_IDLE);

    pbu_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (iter_ctl),
        .i_a     (iter_a),
        .i_b     (r_len),
        .o_done  (iter_done),
        .o_res   (iter_res)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        limit = r_phase ? {1'b0, r_speed} : {1'b0, r_radius};
        scale = r_phase ? {1'b0, r_speed} : {1'b0, r_bounce};
        case (r_cnt[1:0])
            2'd1:    sel_c = r_phase ? r_v[1] : r_p[1];
            2'd2:    sel_c = r_phase ? r_v[2] : r_p[2];
            default: sel_c = r_phase ? r_v[0] : r_p[0];
        endcase
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_SUMSQ: begin
                if (r_cnt == 3'd3) begin
                    m_a = limit;
                    m_b = limit;
                end else begin
                    m_a = mag32(sel_c);
                    m_b = mag32(sel_c);
                end
            end
            ST_DMUL: begin
                m_a = mag32(r_phase ? r_v[r_k] : r_p[r_k]);
                m_b = scale;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Requests into the shared unit.
    always_comb begin
        iter_ctl.start = ((r_state == ST_SUMSQ) && (r_cnt == 3'd4) && (r_acc > r_prod))
                         || (r_state == ST_DGO);
        iter_ctl.op    = (r_state == ST_DGO) ? pbu_pkg::ITER_DIV : pbu_pkg::ITER_SQRT;
        iter_a         = (r_state == ST_DGO) ? r_prod : r_acc;
    end

    // Move and age for the final step.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mv_p[k] = sat32({r_p[k][31], r_p[k]} + {r_v[k][31], r_v[k]});
        end
        mv_age   = (r_age == 16'hFFFF) ? r_age : (r_age + 16'd1);
        mv_alive = !(mv_age >= r_life);
        toward   = r_p[r_k][31] ? iter_res : (32'sd0 - iter_res);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_phase = r_phase;
        n_clr   = r_clr;
        n_done  = 1'b0;
        n_p     = r_p;
        n_v     = r_v;
        n_age   = r_age;
        n_hits  = r_hits;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_len   = r_len;
        n_out   = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == pbu_pkg::IDX_W'(pbu_pkg::PARTICLE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_idx = i_req.particle_index;
                    if (i_req.func == pbu_pkg::FUNC_SPAWN) begin
                        mem_we          = 1'b1;
                        mem_waddr       = i_req.particle_index;
                        mem_wdata.alive = 1'b1;
                        mem_wdata.px    = i_req.start_x;
                        mem_wdata.py    = i_req.start_y;
                        mem_wdata.pz    = i_req.start_z;
                        mem_wdata.vx    = i_req.start_vx;
                        mem_wdata.vy    = i_req.start_vy;
                        mem_wdata.vz    = i_req.start_vz;
                        n_out.out_index   = i_req.particle_index;
                        n_out.pos_x       = i_req.start_x;
                        n_out.pos_y       = i_req.start_y;
                        n_out.pos_z       = i_req.start_z;
                        n_out.is_alive    = 1'b1;
                        n_out.hit_count   = 8'd0;
                        n_out.radius_size = 9'd2;
                        n_done            = 1'b1;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_p[0] = r_rd.px;
                n_p[1] = r_rd.py;
                n_p[2] = r_rd.pz;
                n_v[0] = r_rd.vx;
                n_v[1] = r_rd.vy;
                n_v[2] = r_rd.vz;
                n_age  = r_rd.age;
                n_hits = r_rd.hits;
                if (!r_rd.alive) begin
                    // Dead particle: report the stored entry unchanged.
                    n_out.out_index   = r_idx;
                    n_out.pos_x       = r_rd.px;
                    n_out.pos_y       = r_rd.py;
                    n_out.pos_z       = r_rd.pz;
                    n_out.is_alive    = 1'b0;
                    n_out.hit_count   = r_rd.hits;
                    n_out.radius_size = {1'b0, r_rd.hits} + 9'd2;
                    n_done            = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    n_phase = 1'b0;
                    n_cnt   = '0;
                    n_state = ST_SUMSQ;
                end
            end
            ST_SUMSQ: begin
                // Squares come out of the registered multiplier in the cycle after their operands.
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd1) begin
                    n_acc = r_prod;
                end else if (r_cnt == 3'd2 || r_cnt == 3'd3) begin
                    n_acc = r_acc + r_prod;
                end else if (r_cnt == 3'd4) begin
                    n_cnt = '0;
                    if (r_acc > r_prod) begin
                        n_state = ST_SQRT;
                    end else if (!r_phase) begin
                        n_phase = 1'b1;
                    end else begin
                        n_state = ST_MOVE;
                    end
                end
            end
            ST_SQRT: begin
                if (iter_done) begin
                    n_len   = iter_res;
                    n_k     = '0;
                    n_state = ST_DMUL;
                end
            end
            ST_DMUL: begin
                n_state = ST_DGO;
            end
            ST_DGO: begin
                n_state = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (iter_done) begin
                    if (!r_phase) begin
                        n_v[r_k] = sat32({toward[31], toward} - {r_v[r_k][31], r_v[r_k]});
                    end else begin
                        n_v[r_k] = r_v[r_k][31] ? (32'sd0 - iter_res) : iter_res;
                    end
                    if (r_k == 2'd2) begin
                        if (!r_phase) begin
                            if (r_hits != 8'hFF) begin
                                n_hits = r_hits + 8'd1;
                            end
                            n_phase = 1'b1;
                            n_cnt   = '0;
                            n_state = ST_SUMSQ;
                        end else begin
                            n_state = ST_MOVE;
                        end
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = ST_DMUL;
                    end
                end
            end
            ST_MOVE: begin
                mem_we          = 1'b1;
                mem_wdata.alive = mv_alive;
                mem_wdata.hits  = r_hits;
                mem_wdata.age   = mv_age;
                mem_wdata.px    = mv_p[0];
                mem_wdata.py    = mv_p[1];
                mem_wdata.pz    = mv_p[2];
                mem_wdata.vx    = r_v[0];
                mem_wdata.vy    = r_v[1];
                mem_wdata.vz    = r_v[2];
                n_out.out_index   = r_idx;
                n_out.pos_x       = mv_p[0];
                n_out.pos_y       = mv_p[1];
                n_out.pos_z       = mv_p[2];
                n_out.is_alive    = mv_alive;
                n_out.hit_count   = r_hits;
                n_out.radius_size = {1'b0, r_hits} + 9'd2;
                n_done            = 1'b1;
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_k      <= '0;
            r_phase  <= 1'b0;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_speed  <= pbu_pkg::SPEED_LIMIT_RST;
            r_bounce <= pbu_pkg::BOUNCE_SPEED_RST;
            r_radius <= pbu_pkg::RADIUS_RST;
            r_life   <= pbu_pkg::LIFETIME_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_phase <= n_phase;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    pbu_pkg::CFG_SPEED_LIMIT:  r_speed  <= i_cfg_wdata;
                    pbu_pkg::CFG_BOUNCE_SPEED: r_bounce <= i_cfg_wdata;
                    pbu_pkg::CFG_RADIUS:       r_radius <= i_cfg_wdata;
                    pbu_pkg::CFG_LIFETIME:     r_life   <= i_cfg_wdata[15:0];
                    default:                   r_life   <= r_life;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_v    <= n_v;
        r_age  <= n_age;
        r_hits <= n_hits;
        r_idx  <= n_idx;
        r_acc  <= n_acc;
        r_len  <= n_len;
        r_out  <= n_out;
        r_prod <= m_a * m_b;
    end

    // Particle table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[i_req.particle_index];
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_out;

endmodule

/* src/pbu_iter.sv */
// Shared iterative unit: 64-bit integer square root or 64/32 division,
// one result bit per cycle. Depends on pbu_pkg.
module pbu_iter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pbu_pkg::t_iter_ctl    i_ctl,
    input  logic [63:0]           i_a,
    input  logic [31:0]           i_b,
    output logic                  o_done,
    output logic [31:0]           o_res
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    pbu_pkg::t_iter_op r_op;
    logic [63:0]       r_x;
    logic [33:0]       r_rem;
    logic [31:0]       r_root;
    logic [31:0]       r_b;

    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic [63:0] x_sh;
    logic        ge;

    // One restoring step: shift in the next digit, then compare and subtract.
    always_comb begin
        if (r_op == pbu_pkg::ITER_SQRT) begin
            rem_sh = {r_rem[31:0], r_x[63:62]};
            trial  = {r_root, 2'b01};
            x_sh   = {r_x[61:0], 2'b00};
        end else begin
            rem_sh = {r_rem[32:0], r_x[63]};
            trial  = {2'b00, r_b};
            x_sh   = {r_x[62:0], 1'b0};
        end
        ge = (rem_sh >= trial);
    end

    // Sequencing of the 32 steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(pbu_pkg::ITER_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op   <= i_ctl.op;
            r_b    <= i_b;
            r_root <= '0;
            if (i_ctl.op == pbu_pkg::ITER_SQRT) begin
                r_rem <= '0;
                r_x   <= i_a;
            end else begin
                r_rem <= {2'b00, i_a[63:32]};
                r_x   <= {i_a[31:0], 32'd0};
            end
        end else if (r_busy) begin
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[30:0], ge};
            r_x    <= x_sh;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_root;

endmodule

/* src/pbu_checker.sv */
// Port-level checker for the particle bounce update engine and its bind.
// Depends on pbu_pkg and the particle_bounce_update top level.
module pbu_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input pbu_pkg::t_req              i_req,
    input logic                       o_busy,
    input logic                       o_done,
    input pbu_pkg::t_res              o_res
);

    // The drawn radius always tracks the hit count.
    a_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.radius_size == ({1'b0, o_res.hit_count} + 9'd2)))
        else $error("radius_size does not match hit_count");

    // A step request holds the block busy in the next cycle.
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req.func == pbu_pkg::FUNC_STEP)) |=> o_busy)
        else $error("step request did not make the block busy");

    // A spawn request is answered in the next cycle with the loaded particle.
    a_spawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req.func == pbu_pkg::FUNC_SPAWN)) |=>
        (o_done && o_res.is_alive && (o_res.hit_count == 8'd0)
         && (o_res.pos_x == $past(i_req.start_x))
         && (o_res.out_index == $past(i_req.particle_index))))
        else $error("spawn result wrong or missing");

    // No result strobe right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

endmodule

bind particle_bounce_update pbu_checker u_pbu_checker (.*);

/* tb/particle_bounce_update_tb.sv */
// Self-checking testbench for particle_bounce_update: directed and random requests
// against a fixed-point predictor of the particle table. Depends on pbu_pkg and the RTL.
`timescale 1ns / 1ps

module particle_bounce_update_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    localparam longint S32_MAX    = 64'sd2147483647;
    localparam longint S32_MIN    = -64'sd2147483648;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_start = 1'b0;
    pbu_pkg::t_req              i_req = '0;
    logic                       o_busy;
    logic                       o_done;
    pbu_pkg::t_res              o_res;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_addr = '0;
    logic [pbu_pkg::CFG_W-1:0]  i_cfg_wdata = '0;

    particle_bounce_update uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Mirror of the particle table and the configuration registers.
    longint      pos_tbl [pbu_pkg::PARTICLE_COUNT][3];
    longint      vel_tbl [pbu_pkg::PARTICLE_COUNT][3];
    int unsigned age_tbl [pbu_pkg::PARTICLE_COUNT];
    int unsigned hits_tbl [pbu_pkg::PARTICLE_COUNT];
    bit          alive_tbl [pbu_pkg::PARTICLE_COUNT];
    bit          spawned [pbu_pkg::PARTICLE_COUNT];
    logic [63:0] speed_limit_q  = pbu_pkg::SPEED_LIMIT_RST;
    logic [63:0] bounce_speed_q = pbu_pkg::BOUNCE_SPEED_RST;
    logic [63:0] radius_q       = pbu_pkg::RADIUS_RST;
    logic [63:0] lifetime_q     = pbu_pkg::LIFETIME_RST;

    pbu_pkg::t_res pending_results[$];
    int unsigned   spawned_list[$];
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            quiet_cycles = 0;

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic logic [63:0] sum_squares(longint a, longint b, longint c);
        return magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b)
             + magnitude(c) * magnitude(c);
    endfunction

    // Bitwise integer square root, floor.
    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Component scaled to a new length, truncated toward zero.
    function automatic longint scale_comp(longint c, logic [63:0] scale, logic [63:0] len);
        logic [63:0] q;
        q = (magnitude(c) * scale) / len;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Applies one request to the mirror and returns the entry as it is afterwards.
    function automatic pbu_pkg::t_res predict_entry(pbu_pkg::t_req r);
        int            idx;
        logic [63:0]   ps;
        logic [63:0]   vs;
        logic [63:0]   len;
        longint        toward;
        pbu_pkg::t_res res;
        idx = r.particle_index;
        if (r.func == pbu_pkg::FUNC_SPAWN) begin
            pos_tbl[idx][0] = r.start_x;
            pos_tbl[idx][1] = r.start_y;
            pos_tbl[idx][2] = r.start_z;
            vel_tbl[idx][0] = r.start_vx;
            vel_tbl[idx][1] = r.start_vy;
            vel_tbl[idx][2] = r.start_vz;
            age_tbl[idx] = 0;
            hits_tbl[idx] = 0;
            alive_tbl[idx] = 1'b1;
        end else if (alive_tbl[idx]) begin
            // Bounce off the boundary sphere.
            ps = sum_squares(pos_tbl[idx][0], pos_tbl[idx][1], pos_tbl[idx][2]);
            if (ps > radius_q * radius_q) begin
                len = int_sqrt(ps);
                for (int k = 0; k < 3; k++) begin
                    toward = -scale_comp(pos_tbl[idx][k], bounce_speed_q, len);
                    vel_tbl[idx][k] = sat32(toward - vel_tbl[idx][k]);
                end
                if (hits_tbl[idx] < 255) hits_tbl[idx]++;
            end
            // Clamp the speed.
            vs = sum_squares(vel_tbl[idx][0], vel_tbl[idx][1], vel_tbl[idx][2]);
            if (vs > speed_limit_q * speed_limit_q) begin
                len = int_sqrt(vs);
                for (int k = 0; k < 3; k++)
                    vel_tbl[idx][k] = scale_comp(vel_tbl[idx][k], speed_limit_q, len);
            end
            // Move and age.
            for (int k = 0; k < 3; k++)
                pos_tbl[idx][k] = sat32(pos_tbl[idx][k] + vel_tbl[idx][k]);
            if (age_tbl[idx] < 65535) age_tbl[idx]++;
            if (age_tbl[idx] >= lifetime_q) alive_tbl[idx] = 1'b0;
        end
        res.out_index   = r.particle_index;
        res.pos_x       = pos_tbl[idx][0][31:0];
        res.pos_y       = pos_tbl[idx][1][31:0];
        res.pos_z       = pos_tbl[idx][2][31:0];
        res.is_alive    = alive_tbl[idx];
        res.hit_count   = hits_tbl[idx][7:0];
        res.radius_size = 9'(2 + hits_tbl[idx]);
        return res;
    endfunction

    // Sends one request, with an optional idle gap before it.
    task automatic send_request(pbu_pkg::t_req r);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_entry(r));
        if (r.func == pbu_pkg::FUNC_SPAWN && !spawned[r.particle_index]) begin
            spawned[r.particle_index] = 1'b1;
            spawned_list.push_back(r.particle_index);
        end
    endtask

    // Lets the block finish all work before a register write or the end.
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_results.size() != 0 || o_busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [pbu_pkg::CFG_W-1:0] data);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (addr)
            pbu_pkg::CFG_SPEED_LIMIT:  speed_limit_q  = data;
            pbu_pkg::CFG_BOUNCE_SPEED: bounce_speed_q = data;
            pbu_pkg::CFG_RADIUS:       radius_q       = data;
            pbu_pkg::CFG_LIFETIME:     lifetime_q     = data[15:0];
            default:                   lifetime_q     = lifetime_q;
        endcase
    endtask

    task automatic write_all(logic [30:0] spd, logic [30:0] bnc, logic [30:0] rad,
                             logic [15:0] life);
        write_reg(pbu_pkg::CFG_SPEED_LIMIT, spd);
        write_reg(pbu_pkg::CFG_BOUNCE_SPEED, bnc);
        write_reg(pbu_pkg::CFG_RADIUS, rad);
        write_reg(pbu_pkg::CFG_LIFETIME, {15'd0, life});
    endtask

    // Coordinate: full range, near the default boundary, small, or an extreme.
    function automatic logic [31:0] rand_value(int near_bits);
        case ($urandom_range(7))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3:    return 32'($urandom_range(0, 32'd1 << 26)) - (32'd1 << 25);
            default: return 32'($urandom_range(0, 32'd1 << near_bits))
                          - (32'd1 << (near_bits - 1));
        endcase
    endfunction

    function automatic pbu_pkg::t_req make_spawn(int idx, int pos_bits, int vel_bits);
        pbu_pkg::t_req r;
        r.func = pbu_pkg::FUNC_SPAWN;
        r.particle_index = pbu_pkg::IDX_W'(idx);
        r.start_x  = rand_value(pos_bits);
        r.start_y  = rand_value(pos_bits);
        r.start_z  = rand_value(pos_bits);
        r.start_vx = rand_value(vel_bits);
        r.start_vy = rand_value(vel_bits);
        r.start_vz = rand_value(vel_bits);
        return r;
    endfunction

    function automatic pbu_pkg::t_req make_step(int idx);
        pbu_pkg::t_req r;
        r = '0;
        r.func = pbu_pkg::FUNC_STEP;
        r.particle_index = pbu_pkg::IDX_W'(idx);
        // Spawn fields are ignored on a step; drive them with noise anyway.
        r.start_x = $urandom;
        r.start_vz = $urandom;
        return r;
    endfunction

    // Extremes of every field, bounce with saturation, clamp and dead steps.
    task automatic test_directed();
        pbu_pkg::t_req r;
        r = '{pbu_pkg::FUNC_SPAWN, 10'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_request(r);
        send_request(make_step(0));
        send_request(make_step(0));
        r = '{pbu_pkg::FUNC_SPAWN, 10'd1023, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_request(r);
        send_request(make_step(1023));
        send_request(make_step(1023));
        // Particle at rest at the origin: no bounce, no clamp.
        r = '{pbu_pkg::FUNC_SPAWN, 10'd5, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        send_request(r);
        send_request(make_step(5));
        // Inside the boundary but too fast.
        r = '{pbu_pkg::FUNC_SPAWN, 10'd6, 32'sd65536, -32'sd65536, 32'sd0,
              32'sd9000000, -32'sd7000000, 32'sd123457};
        send_request(r);
        send_request(make_step(6));
        send_request(make_step(6));
        // Lifetime of one tick: dies on the first step, then stays dead.
        write_reg(pbu_pkg::CFG_LIFETIME, 31'd1);
        send_request(make_step(6));
        send_request(make_step(6));
        send_request(make_step(6));
        // Zero lifetime also kills on the first step.
        write_reg(pbu_pkg::CFG_LIFETIME, 31'd0);
        send_request(make_spawn(7, 26, 20));
        send_request(make_step(7));
        send_request(make_step(7));
        write_all(pbu_pkg::SPEED_LIMIT_RST, pbu_pkg::BOUNCE_SPEED_RST, pbu_pkg::RADIUS_RST,
                  pbu_pkg::LIFETIME_RST);
    endtask

    // Zero radius bounces every step, so the hit count reaches saturation.
    task automatic test_hit_saturation();
        pbu_pkg::t_req r;
        write_all(31'h7FFF_FFFF, 31'd65536, 31'd0, 16'hFFFF);
        r = make_spawn(9, 20, 16);
        r.start_x = 32'sd1 << 20;
        send_request(r);
        repeat (262) send_request(make_step(9));
    endtask

    // Spawn/step mix over a small pool of entries, with some full-range indexes.
    task automatic run_random(int count, int spawn_pct, int pos_bits, int vel_bits);
        int idx;
        for (int n = 0; n < count; n++) begin
            if (spawned_list.size() == 0 || $urandom_range(99) < spawn_pct) begin
                idx = $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(15);
                send_request(make_spawn(idx, pos_bits, vel_bits));
            end else if ($urandom_range(3) == 0) begin
                send_request(make_step(spawned_list[$urandom_range(spawned_list.size() - 1)]));
            end else begin
                send_request(make_step(spawned_list[$urandom_range(
                    spawned_list.size() < 8 ? spawned_list.size() - 1 : 7)]));
            end
        end
    endtask

    task automatic test_random_phases();
        // Registers left by the hit-saturation test, light sender gaps.
        send_idle_pct = 9;
        run_random(380, 20, 26, 21);
        // Register extremes, heavy sender gaps.
        write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1 << 24, 16'hFFFF);
        send_idle_pct = 67;
        run_random(200, 15, 26, 24);
        write_all(31'd0, 31'd0, 31'h7FFF_FFFF, 16'd1);
        run_random(80, 40, 26, 21);
        // Random registers, short lifetimes, back to back.
        write_all(31'($urandom_range(1 << 22)), 31'($urandom_range(1 << 23)),
                  31'($urandom_range(1 << 25)), 16'($urandom_range(2, 40)));
        send_idle_pct = 0;
        run_random(460, 15, 27, 22);
    endtask

    // Result checker: each strobe is compared with the oldest prediction.
    always @(posedge i_clk) begin
        pbu_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result for entry %0d", o_res.out_index);
            end else begin
                want = pending_results.pop_front();
                if (o_res.out_index !== want.out_index || o_res.pos_x !== want.pos_x
                        || o_res.pos_y !== want.pos_y || o_res.pos_z !== want.pos_z
                        || o_res.is_alive !== want.is_alive
                        || o_res.hit_count !== want.hit_count
                        || o_res.radius_size !== want.radius_size) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: entry %0d expected %p got %p",
                                 want.out_index, want, o_res);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request and no result.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("particle_bounce_update_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_hit_saturation();
        test_random_phases();
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("particle_bounce_update_tb passed");
        end else begin
            $display("particle_bounce_update_tb failed");
        end
        $finish;
    end

endmodule
